FILE: rtl/core/der_tlv_header_parser_top_macros.svh
// Assertion macros used by the DER TLV header parser RTL.
// Each macro takes a label, clock, reset and the two expressions of an implication.
`ifndef DER_TLV_HEADER_PARSER_TOP_MACROS_SVH
`define DER_TLV_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DTLV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtlv assertion failed");

// Next-cycle implication, disabled while in reset.
`define DTLV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtlv assertion failed");

`endif

FILE: rtl/core/dtlv_pkg.sv
// Shared types and codes for the DER TLV header parser.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package dtlv_pkg;

  localparam int CONTENT_LENGTH_W = 31;
  localparam int LENGTH_WIDTH_DEF = 31;

  localparam logic [1:0] CLASS_TAG   = 2'd0;
  localparam logic [1:0] CLASS_LEN   = 2'd1;
  localparam logic [1:0] CLASS_VALUE = 2'd2;
  localparam logic [1:0] CLASS_SKIP  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_LEN   = 3'd1;
  localparam logic [2:0] ERR_LONG_CUT = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW = 3'd3;
  localparam logic [2:0] ERR_PAYLOAD  = 3'd4;
  localparam logic [2:0] ERR_WRONG_TAG = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
    logic [4:0] want_tag;
    logic       check_tag;
  } item_t;

  typedef struct packed {
    logic [1:0]                  byte_class;
    logic [4:0]                  tag_number;
    logic [CONTENT_LENGTH_W-1:0] content_length;
    logic [7:0]                  value_out;
    logic                        element_end;
    logic [2:0]                  error_code;
  } result_t;

endpackage

FILE: rtl/core/dtlv_in_stage.sv
// Input register stage of the DER TLV header parser.
// Depends on dtlv_pkg for the item type.
`timescale 1ns / 1ps

module dtlv_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtlv_pkg::item_t item_in,
  input  logic            advance,
  output logic            held_valid,
  output dtlv_pkg::item_t held_item
);

  // Free when empty or when the held byte moves on this cycle.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= item_in;
    end
  end

endmodule

FILE: rtl/core/dtlv_parser.sv
// Phase state and per-byte decode of the DER TLV header parser.
// Depends on dtlv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "der_tlv_header_parser_top_macros.svh"

module dtlv_parser #(
  parameter int LENGTH_WIDTH = dtlv_pkg::LENGTH_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  dtlv_pkg::item_t   item,
  output dtlv_pkg::result_t res
);

  localparam logic [2:0] PH_TAG      = 3'd0;
  localparam logic [2:0] PH_LEN      = 3'd1;
  localparam logic [2:0] PH_LONG     = 3'd2;
  localparam logic [2:0] PH_LONG_OVF = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;
  localparam logic [2:0] PH_SKIP     = 3'd5;

  localparam int CLW = dtlv_pkg::CONTENT_LENGTH_W;

  logic [2:0]              phase, phase_next;
  logic [4:0]              held_tag, held_tag_next;
  logic [6:0]              length_bytes_left, length_bytes_left_next;
  logic [LENGTH_WIDTH-1:0] length_accumulator, length_accumulator_next;
  logic [LENGTH_WIDTH-1:0] value_bytes_left, value_bytes_left_next;

  logic [LENGTH_WIDTH+7:0] acc_wide;
  logic [LENGTH_WIDTH-1:0] acc_shifted;
  logic [LENGTH_WIDTH-1:0] acc_upd;
  logic [6:0]              lbl_dec;
  logic                    acc_too_big;
  logic                    ovf;
  logic                    fail;
  logic                    end_clean;
  logic                    err_mid;
  logic                    skip_quiet;

  assign acc_wide    = {length_accumulator, item.data_byte};
  assign acc_shifted = acc_wide[LENGTH_WIDTH-1:0];
  // Any of the top eight bits set means another shift would drop length bits.
  assign acc_too_big = (length_accumulator[LENGTH_WIDTH-1 -: 8] != 8'd0);

  always_comb begin
    phase_next              = phase;
    held_tag_next           = held_tag;
    length_bytes_left_next  = length_bytes_left;
    length_accumulator_next = length_accumulator;
    value_bytes_left_next   = value_bytes_left;
    res                     = '0;
    res.byte_class          = dtlv_pkg::CLASS_SKIP;
    fail                    = 1'b0;
    ovf                     = 1'b0;
    acc_upd                 = length_accumulator;
    lbl_dec                 = length_bytes_left;

    case (phase)
      PH_TAG: begin
        held_tag_next           = item.data_byte[4:0];
        length_accumulator_next = '0;
        res.byte_class          = dtlv_pkg::CLASS_TAG;
        res.tag_number          = item.data_byte[4:0];
        if (item.buffer_last) begin
          res.error_code = dtlv_pkg::ERR_NO_LEN;
          fail           = 1'b1;
        end else if (item.check_tag && (item.data_byte[4:0] != item.want_tag)) begin
          res.error_code = dtlv_pkg::ERR_WRONG_TAG;
          fail           = 1'b1;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        res.byte_class = dtlv_pkg::CLASS_LEN;
        res.tag_number = held_tag;
        if (item.data_byte[7]) begin
          length_accumulator_next = '0;
          if (item.data_byte[6:0] == 7'd0) begin
            res.element_end = 1'b1;
            phase_next      = PH_TAG;
          end else if (item.buffer_last) begin
            res.error_code = dtlv_pkg::ERR_LONG_CUT;
            fail           = 1'b1;
          end else begin
            length_bytes_left_next = item.data_byte[6:0];
            phase_next             = PH_LONG;
          end
        end else begin
          length_accumulator_next = LENGTH_WIDTH'(item.data_byte);
          res.content_length      = CLW'(item.data_byte);
          if (item.data_byte == 8'd0) begin
            res.element_end = 1'b1;
            phase_next      = PH_TAG;
          end else if (item.buffer_last) begin
            res.error_code = dtlv_pkg::ERR_PAYLOAD;
            fail           = 1'b1;
          end else begin
            value_bytes_left_next = LENGTH_WIDTH'(item.data_byte);
            phase_next            = PH_VALUE;
          end
        end
      end
      PH_LONG, PH_LONG_OVF: begin
        res.byte_class = dtlv_pkg::CLASS_LEN;
        res.tag_number = held_tag;
        ovf            = (phase == PH_LONG_OVF);
        if (!ovf) begin
          if (acc_too_big) begin
            ovf = 1'b1;
          end else begin
            acc_upd = acc_shifted;
          end
        end
        length_accumulator_next = acc_upd;
        res.content_length      = CLW'(acc_upd);
        if (length_bytes_left != 7'd0) begin
          lbl_dec = length_bytes_left - 7'd1;
        end
        length_bytes_left_next = lbl_dec;
        if (lbl_dec == 7'd0) begin
          if (ovf) begin
            res.error_code = dtlv_pkg::ERR_OVERFLOW;
            fail           = 1'b1;
          end else if (acc_upd == '0) begin
            res.element_end = 1'b1;
            phase_next      = PH_TAG;
          end else if (item.buffer_last) begin
            res.error_code = dtlv_pkg::ERR_PAYLOAD;
            fail           = 1'b1;
          end else begin
            value_bytes_left_next = acc_upd;
            phase_next            = PH_VALUE;
          end
        end else if (item.buffer_last) begin
          res.error_code = dtlv_pkg::ERR_LONG_CUT;
          fail           = 1'b1;
        end else begin
          phase_next = ovf ? PH_LONG_OVF : PH_LONG;
        end
      end
      PH_VALUE: begin
        res.byte_class     = dtlv_pkg::CLASS_VALUE;
        res.tag_number     = held_tag;
        res.content_length = CLW'(length_accumulator);
        res.value_out      = item.data_byte;
        if (value_bytes_left <= LENGTH_WIDTH'(1)) begin
          value_bytes_left_next = '0;
          res.element_end       = 1'b1;
          phase_next            = PH_TAG;
        end else begin
          value_bytes_left_next = value_bytes_left - LENGTH_WIDTH'(1);
          if (item.buffer_last) begin
            res.error_code = dtlv_pkg::ERR_PAYLOAD;
            fail           = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (item.buffer_last) begin
          phase_next = PH_TAG;
        end
      end
      default: begin
        phase_next = PH_TAG;
      end
    endcase

    // Drop the rest of the buffer after an error.
    if (fail) begin
      phase_next = item.buffer_last ? PH_TAG : PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TAG;
      held_tag           <= '0;
      length_bytes_left  <= '0;
      length_accumulator <= '0;
      value_bytes_left   <= '0;
    end else if (fire) begin
      phase              <= phase_next;
      held_tag           <= held_tag_next;
      length_bytes_left  <= length_bytes_left_next;
      length_accumulator <= length_accumulator_next;
      value_bytes_left   <= value_bytes_left_next;
    end
  end

  assign end_clean  = (res.error_code == dtlv_pkg::ERR_NONE) &&
                      (res.byte_class != dtlv_pkg::CLASS_SKIP);
  assign err_mid    = (res.error_code != dtlv_pkg::ERR_NONE) && !item.buffer_last;
  assign skip_quiet = (res.tag_number == 5'd0) && (res.content_length == '0) &&
                      (res.error_code == dtlv_pkg::ERR_NONE);

  `DTLV_ASSERT_IMPL(a_end_clean, clk, rst, fire && res.element_end, end_clean)
  `DTLV_ASSERT_NEXT(a_last_to_tag, clk, rst, fire && item.buffer_last, phase == PH_TAG)
  `DTLV_ASSERT_NEXT(a_err_skips, clk, rst, fire && err_mid, phase == PH_SKIP)
  `DTLV_ASSERT_IMPL(a_skip_quiet, clk, rst, fire && (phase == PH_SKIP), skip_quiet)

endmodule

FILE: rtl/core/dtlv_out_stage.sv
// Result register stage of the DER TLV header parser.
// Depends on dtlv_pkg for the result type.
`timescale 1ns / 1ps

module dtlv_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dtlv_pkg::result_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output dtlv_pkg::result_t res_out
);

  // Room when empty or when the current result leaves this cycle.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

FILE: rtl/core/der_tlv_header_parser_top.sv
// Top level of the DER TLV header parser: input stage, decoder, result stage.
// Depends on dtlv_pkg, dtlv_in_stage, dtlv_parser and dtlv_out_stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_ready  | data_byte, buffer_last, want_tag,
//            |                      | check_tag
//   out      | out_valid / out_ready| byte_class, tag_number, content_length,
//            |                      | value_out, element_end, error_code
//
// One byte per cycle sustained while out is ready; every transfer in yields exactly one transfer out.
// Each byte is held first in the input register, then in the result register.
// The phase update for a byte happens as it moves from input to result register.
// Reset (rst, synchronous) returns the parser to expect a tag byte, both stages empty.
// A stall on out holds the result and, once the input register is full, in_ready drops.
`timescale 1ns / 1ps

module der_tlv_header_parser_top #(
  parameter int LENGTH_WIDTH = dtlv_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            data_byte,
  input  logic                                  buffer_last,
  input  logic [4:0]                            want_tag,
  input  logic                                  check_tag,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            byte_class,
  output logic [4:0]                            tag_number,
  output logic [dtlv_pkg::CONTENT_LENGTH_W-1:0] content_length,
  output logic [7:0]                            value_out,
  output logic                                  element_end,
  output logic [2:0]                            error_code
);

  dtlv_pkg::item_t   item_in;
  dtlv_pkg::item_t   held_item;
  dtlv_pkg::result_t res_comb;
  dtlv_pkg::result_t res_reg;
  logic              held_valid;
  logic              can_load;
  logic              advance;

  // Pack the input ports into one item.
  assign item_in.data_byte    = data_byte;
  assign item_in.buffer_last  = buffer_last;
  assign item_in.want_tag     = want_tag;
  assign item_in.check_tag    = check_tag;

  // Advance the held byte when the result register has room; this is also
  // the only cycle in which the parser state moves.
  assign advance = held_valid && can_load;

  dtlv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  dtlv_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (held_item),
    .res  (res_comb)
  );

  dtlv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (res_comb),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_reg)
  );

  // Unpack the registered result onto the output ports.
  assign byte_class     = res_reg.byte_class;
  assign tag_number     = res_reg.tag_number;
  assign content_length = res_reg.content_length;
  assign value_out      = res_reg.value_out;
  assign element_end    = res_reg.element_end;
  assign error_code     = res_reg.error_code;

endmodule
